/* rtl/assert_macros.svh */
// Assertion macros for the RTL files of the command parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle; quiet while in reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle; quiet while in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lcp_pkg.sv */
// Types, constants and matching functions for the line command parser.
`timescale 1ns / 1ps
`default_nettype none

package lcp_pkg;

    // Line buffer capacity; one slot is kept back, so a line stores at most CAP-1 bytes
    localparam int LINE_CAPACITY = 128;
    localparam int CHARS_W       = $clog2(LINE_CAPACITY);
    localparam logic [CHARS_W-1:0] CHARS_MAX = CHARS_W'(LINE_CAPACITY - 1);

    // Keyword candidate bit positions
    localparam int KW_N     = 4;
    localparam int KW_ON    = 0;
    localparam int KW_OFF   = 1;
    localparam int KW_SET   = 2;
    localparam int KW_STATS = 3;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [6:0] LEVEL_MAX = 7'd100;

    typedef enum logic [2:0] {
        KIND_ECHO    = 3'd0,
        KIND_SET     = 3'd1,
        KIND_STATS   = 3'd2,
        KIND_RANGE   = 3'd3,
        KIND_UNKNOWN = 3'd4
    } result_kind_t;

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_STOP   = 2'd2
    } number_phase_t;

    // Keywords still possible once the text ends at length len
    function automatic logic [KW_N-1:0] len_keep(input logic [CHARS_W-1:0] len);
        logic [KW_N-1:0] keep;
        keep[KW_ON]    = (len >= CHARS_W'(2));
        keep[KW_OFF]   = (len >= CHARS_W'(3));
        keep[KW_SET]   = (len >= CHARS_W'(4));
        keep[KW_STATS] = (len >= CHARS_W'(5));
        return keep;
    endfunction

    // Keywords that agree with byte c at position pos
    function automatic logic [KW_N-1:0] text_keep(input logic [CHARS_W-1:0] pos,
                                                  input logic [7:0] c);
        logic [KW_N-1:0] keep;
        keep[KW_ON]    = (pos == CHARS_W'(0) && c == "O") ||
                         (pos == CHARS_W'(1) && c == "N");
        keep[KW_OFF]   = (pos == CHARS_W'(0) && c == "O") ||
                         (pos == CHARS_W'(1) && c == "F") ||
                         (pos == CHARS_W'(2) && c == "F");
        keep[KW_SET]   = (pos >= CHARS_W'(4)) ||
                         (pos == CHARS_W'(0) && c == "S") ||
                         (pos == CHARS_W'(1) && c == "E") ||
                         (pos == CHARS_W'(2) && c == "T") ||
                         (pos == CHARS_W'(3) && c == ":");
        keep[KW_STATS] = (pos == CHARS_W'(0) && c == "S") ||
                         (pos == CHARS_W'(1) && c == "T") ||
                         (pos == CHARS_W'(2) && c == "A") ||
                         (pos == CHARS_W'(3) && c == "T") ||
                         (pos == CHARS_W'(4) && c == "S");
        return keep;
    endfunction

endpackage

`default_nettype wire

/* rtl/line_command_parser_core.sv */
// Line command parser: byte-at-a-time keyword match, value parse and counters.
// An accepted byte waits in the input register until the result register is
// free. Throughput: one byte per cycle unless result_stall holds the result
// register; the per-byte match and multiply-add sit between the two registers.
// Bytes that give no result (empty lines, overflow bytes) are still consumed.
// Reset (rst_n low, asynchronous) empties both registers, clears the line state
// and zeroes both counters; the block is ready once reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module line_command_parser_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input channel
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire logic [7:0]   rx_byte,
    // result channel
    output logic              result_valid,
    input  wire logic         result_stall,
    output logic [2:0]        result_kind,
    output logic [7:0]        echo_byte,
    output logic [6:0]        target_level,
    output logic [31:0]       commands_total,
    output logic [31:0]       errors_total
);

    // Input stage
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;

    // Line state
    logic [lcp_pkg::CHARS_W-1:0] chars_reg,  chars_next;
    logic                        nul_seen_reg, nul_seen_next;
    logic                        line_empty_reg, line_empty_next;
    logic [lcp_pkg::KW_N-1:0]    cand_reg,   cand_next;
    lcp_pkg::number_phase_t      phase_reg,  phase_next;
    logic [6:0]                  value_reg,  value_next;
    logic                        over_reg,   over_next;
    logic                        neg_reg,    neg_next;
    logic [31:0]                 cmd_count_reg, cmd_count_next;
    logic [31:0]                 err_count_reg, err_count_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    lcp_pkg::result_kind_t  kind_reg,   kind_next;
    logic [7:0]             echo_reg,   echo_next;
    logic [6:0]             target_reg, target_next;
    logic [31:0]            cmd_out_reg, err_out_reg;

    // Handshake
    logic out_free;
    logic advance;
    logic accept;
    logic res_load;

    // Per-byte decode
    logic        is_eol;
    logic        is_digit;
    logic        is_blank;
    logic        is_sign;
    logic [9:0]  num_sum;
    logic [lcp_pkg::KW_N-1:0] cand_end;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;
    assign accept     = byte_valid && !byte_stall;

    assign is_eol   = (s1_byte_reg == lcp_pkg::CH_LF) || (s1_byte_reg == lcp_pkg::CH_CR);
    assign is_digit = (s1_byte_reg >= lcp_pkg::CH_ZERO) && (s1_byte_reg <= lcp_pkg::CH_NINE);
    assign is_blank = (s1_byte_reg == lcp_pkg::CH_SPACE) || (s1_byte_reg == lcp_pkg::CH_TAB) ||
                      (s1_byte_reg == lcp_pkg::CH_VT)    || (s1_byte_reg == lcp_pkg::CH_FF);
    assign is_sign  = (s1_byte_reg == lcp_pkg::CH_PLUS) || (s1_byte_reg == lcp_pkg::CH_MINUS);
    // digits 0x30..0x39 carry their value in the low nibble
    assign num_sum  = {3'b000, value_reg} * 10'd10 + {6'b000000, s1_byte_reg[3:0]};
    assign cand_end = nul_seen_reg ? cand_reg : (cand_reg & lcp_pkg::len_keep(chars_reg));

    // Next line state and result for the byte in the input stage
    always_comb
    begin
        chars_next      = chars_reg;
        nul_seen_next   = nul_seen_reg;
        line_empty_next = line_empty_reg;
        cand_next       = cand_reg;
        phase_next      = phase_reg;
        value_next      = value_reg;
        over_next       = over_reg;
        neg_next        = neg_reg;
        cmd_count_next  = cmd_count_reg;
        err_count_next  = err_count_reg;
        res_load        = 1'b0;
        kind_next       = lcp_pkg::KIND_ECHO;
        echo_next       = 8'h00;
        target_next     = 7'd0;

        if (advance)
        begin
            if (is_eol)
            begin
                if (chars_reg != '0)
                begin
                    // line ends: start afresh
                    chars_next      = '0;
                    nul_seen_next   = 1'b0;
                    line_empty_next = 1'b0;
                    cand_next       = '1;
                    phase_next      = lcp_pkg::NUM_SKIP;
                    value_next      = 7'd0;
                    over_next       = 1'b0;
                    neg_next        = 1'b0;
                    if (!line_empty_reg)
                    begin
                        res_load       = 1'b1;
                        cmd_count_next = cmd_count_reg + 32'd1;
                        priority if (cand_end[lcp_pkg::KW_ON])
                        begin
                            kind_next   = lcp_pkg::KIND_SET;
                            target_next = lcp_pkg::LEVEL_MAX;
                        end
                        else if (cand_end[lcp_pkg::KW_OFF])
                        begin
                            kind_next   = lcp_pkg::KIND_SET;
                        end
                        else if (cand_end[lcp_pkg::KW_SET])
                        begin
                            if (over_reg || (neg_reg && value_reg != 7'd0))
                            begin
                                kind_next      = lcp_pkg::KIND_RANGE;
                                err_count_next = err_count_reg + 32'd1;
                            end
                            else
                            begin
                                kind_next   = lcp_pkg::KIND_SET;
                                target_next = value_reg;
                            end
                        end
                        else if (cand_end[lcp_pkg::KW_STATS])
                        begin
                            kind_next = lcp_pkg::KIND_STATS;
                        end
                        else
                        begin
                            kind_next      = lcp_pkg::KIND_UNKNOWN;
                            err_count_next = err_count_reg + 32'd1;
                        end
                    end
                end
            end
            else if (chars_reg < lcp_pkg::CHARS_MAX)
            begin
                // stored and echoed; only text before a NUL is matched
                if (!nul_seen_reg)
                begin
                    if (s1_byte_reg == lcp_pkg::CH_NUL)
                    begin
                        nul_seen_next   = 1'b1;
                        line_empty_next = (chars_reg == '0);
                        cand_next       = cand_reg & lcp_pkg::len_keep(chars_reg);
                    end
                    else
                    begin
                        cand_next = cand_reg & lcp_pkg::text_keep(chars_reg, s1_byte_reg);
                        // value text after the SET: prefix
                        if (chars_reg >= lcp_pkg::CHARS_W'(4))
                        begin
                            if (phase_reg == lcp_pkg::NUM_SKIP && is_sign)
                            begin
                                neg_next   = (s1_byte_reg == lcp_pkg::CH_MINUS);
                                phase_next = lcp_pkg::NUM_DIGITS;
                            end
                            else if (phase_reg == lcp_pkg::NUM_SKIP && is_blank)
                            begin
                                phase_next = phase_reg;
                            end
                            else if (phase_reg != lcp_pkg::NUM_STOP)
                            begin
                                phase_next = is_digit ? lcp_pkg::NUM_DIGITS : lcp_pkg::NUM_STOP;
                                if (is_digit && !over_reg)
                                begin
                                    if (num_sum > 10'(lcp_pkg::LEVEL_MAX))
                                        over_next = 1'b1;
                                    else
                                        value_next = num_sum[6:0];
                                end
                            end
                        end
                    end
                end
                chars_next = chars_reg + lcp_pkg::CHARS_W'(1);
                res_load   = 1'b1;
                echo_next  = s1_byte_reg;
            end
        end

        out_valid_next = res_load || (out_valid_reg && result_stall);
    end

    // Control and line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            chars_reg      <= '0;
            nul_seen_reg   <= 1'b0;
            line_empty_reg <= 1'b0;
            cand_reg       <= '1;
            phase_reg      <= lcp_pkg::NUM_SKIP;
            value_reg      <= 7'd0;
            over_reg       <= 1'b0;
            neg_reg        <= 1'b0;
            cmd_count_reg  <= 32'd0;
            err_count_reg  <= 32'd0;
        end
        else
        begin
            s1_valid_reg   <= accept || (s1_valid_reg && !advance);
            out_valid_reg  <= out_valid_next;
            chars_reg      <= chars_next;
            nul_seen_reg   <= nul_seen_next;
            line_empty_reg <= line_empty_next;
            cand_reg       <= cand_next;
            phase_reg      <= phase_next;
            value_reg      <= value_next;
            over_reg       <= over_next;
            neg_reg        <= neg_next;
            cmd_count_reg  <= cmd_count_next;
            err_count_reg  <= err_count_next;
        end
    end

    // Payload registers: input byte and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_byte_reg <= rx_byte;
        if (res_load)
        begin
            kind_reg    <= kind_next;
            echo_reg    <= echo_next;
            target_reg  <= target_next;
            cmd_out_reg <= cmd_count_next;
            err_out_reg <= err_count_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign result_kind    = kind_reg;
    assign echo_byte      = echo_reg;
    assign target_level   = target_reg;
    assign commands_total = cmd_out_reg;
    assign errors_total   = err_out_reg;

    // Checks
    `ASSERT_IMPL(a_chars_cap, 1'b1, chars_reg <= lcp_pkg::CHARS_MAX)
    `ASSERT_IMPL(a_empty_has_nul, line_empty_reg, nul_seen_reg && chars_reg != '0)
    `ASSERT_IMPL(a_err_with_beat, err_count_reg != $past(err_count_reg), result_valid && (result_kind == lcp_pkg::KIND_RANGE || result_kind == lcp_pkg::KIND_UNKNOWN))
    `ASSERT_NEXT(a_cmd_step, !advance, cmd_count_reg == $past(cmd_count_reg))

endmodule

`default_nettype wire
